// ----- sv/sodd_pkg.sv -----
`default_nettype none

package sodd_pkg;

  localparam int SAMPLE_W = 32;
  localparam int LEVEL_W  = 15;
  localparam int WORD_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int BITS_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_BITS    = 2'd0,
    CFG_DITHER_MODE = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DM_NONE   = 2'd0,
    DM_SINGLE = 2'd1,
    DM_TPDF   = 2'd2,
    DM_WIDE   = 2'd3
  } dither_mode_t;

  typedef struct packed {
    logic              step;
    dither_mode_t      mode;
    logic [BITS_W-1:0] bits;
  } dith_ctl_t;

  localparam logic [BITS_W-1:0] OUT_BITS_RST    = 4'd6;
  localparam dither_mode_t      DITHER_MODE_RST = DM_WIDE;

  localparam logic [15:0] LCG_A_MUL = 16'd25173;
  localparam logic [15:0] LCG_A_ADD = 16'd13847;
  localparam logic [14:0] LCG_B_MUL = 15'd24645;
  localparam logic [14:0] LCG_B_ADD = 15'd1703;
  localparam logic [31:0] LCG_W_MUL = 32'd214013;
  localparam logic [31:0] LCG_W_ADD = 32'd2531011;

  localparam logic [15:0] GEN_A_SEED = 16'hBEEF;
  localparam logic [14:0] GEN_B_SEED = 15'h700D;
  localparam logic [31:0] GEN_C_SEED = 32'hDEADBEEF;
  localparam logic [31:0] GEN_D_SEED = 32'hD00DFEED;

  function automatic logic [15:0] lcg_a(input logic [15:0] v);
    return 16'(v * LCG_A_MUL + LCG_A_ADD);
  endfunction

  function automatic logic [14:0] lcg_b(input logic [14:0] v);
    return 15'(v * LCG_B_MUL + LCG_B_ADD);
  endfunction

  function automatic logic [31:0] lcg_w(input logic [31:0] v);
    return 32'(v * LCG_W_MUL + LCG_W_ADD);
  endfunction

endpackage

`default_nettype wire

// ----- sv/sodd_ifs.sv -----
`default_nettype none

interface sodd_in_if;
  import sodd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sodd_out_if;
  import sodd_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface sodd_cfg_if;
  import sodd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/sodd_dither.sv -----
`default_nettype none

module sodd_dither import sodd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dith_ctl_t         ctl,
  output logic      [WORD_W-1:0] dith
);

  // each generator register holds the value the next word consumes
  logic [15:0] gen_a_r, gen_a_nxt;
  logic [14:0] gen_b_r, gen_b_nxt;
  logic [31:0] gen_c_r, gen_c_nxt;
  logic [31:0] gen_d_r, gen_d_nxt;

  logic [WORD_W-1:0] a_sh, b_sh, c_sh, d_sh;
  logic [4:0]        wide_amt;

  assign gen_a_nxt = lcg_a(gen_a_r);
  assign gen_b_nxt = lcg_b(gen_b_r);
  assign gen_c_nxt = lcg_w(gen_c_r);
  assign gen_d_nxt = lcg_w(gen_d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_a_r <= lcg_a(GEN_A_SEED);
      gen_b_r <= lcg_b(GEN_B_SEED);
      gen_c_r <= lcg_w(GEN_C_SEED);
      gen_d_r <= lcg_w(GEN_D_SEED);
    end else if (ctl.step) begin
      if (ctl.mode == DM_SINGLE || ctl.mode == DM_TPDF) begin
        gen_a_r <= gen_a_nxt;
      end
      if (ctl.mode == DM_TPDF) begin
        gen_b_r <= gen_b_nxt;
      end
      if (ctl.mode == DM_WIDE) begin
        gen_c_r <= gen_c_nxt;
        gen_d_r <= gen_d_nxt;
      end
    end
  end

  // clamp the wide shift to pure sign fill
  assign wide_amt = (ctl.bits >= 4'd13) ? 5'd31 : 5'(ctl.bits) + 5'd18;

  assign a_sh = 16'($signed(gen_a_r) >>> ctl.bits);
  assign b_sh = {1'b0, 15'(gen_b_r >> (ctl.bits - 4'd1))};
  assign c_sh = 16'($signed(gen_c_r) >>> wide_amt);
  assign d_sh = 16'($signed(gen_d_r) >>> wide_amt);

  always_comb begin
    unique case (ctl.mode)
      DM_NONE:   dith = '0;
      DM_SINGLE: dith = a_sh;
      DM_TPDF:   dith = a_sh + b_sh;
      DM_WIDE:   dith = c_sh + d_sh;
      default:   dith = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/second_order_sigma_delta_dither_unit.sv -----
`default_nettype none

// channel   dir  payload                       handshake
// in_ch     in   sample [31:0] signed          valid / ready
// out_ch    out  level [14:0]                  valid / ready
// cfg_ch    in   index [1:0], data [3:0]       valid / ready (ready tied high)
//
// One word per cycle unless out_ch stalls; a word is held in the input register,
// then computed and registered into level_r, which drives out_ch; error and
// generator feedback updates as each word moves into level_r.
// Reset (synchronous, rst_n low) empties both registers, zeroes the errors,
// seeds the generators and restores out_bits = 6, dither_mode = 3.
// A stalled output holds its word; the input still accepts while it is taken.

module second_order_sigma_delta_dither_unit import sodd_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  sodd_in_if.sink    in_ch,
  sodd_out_if.source out_ch,
  sodd_cfg_if.sink   cfg_ch
);

  logic [BITS_W-1:0]   out_bits_r;
  dither_mode_t        dither_mode_r;

  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [WORD_W-1:0]   err_last_r, err_prev_r;

  logic                advance;
  logic [BITS_W-1:0]   n_eff;
  logic [4:0]          frac;
  logic [WORD_W-1:0]   w_base, w, dith, mask, inc, q, e;
  dith_ctl_t           dctl;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_bits_r    <= OUT_BITS_RST;
      dither_mode_r <= DITHER_MODE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_OUT_BITS:    out_bits_r    <= cfg_ch.data[BITS_W-1:0];
        CFG_DITHER_MODE: dither_mode_r <= dither_mode_t'(cfg_ch.data[1:0]);
        default: ;
      endcase
    end
  end

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r <= in_ch.sample;
    end
  end

  assign n_eff = (out_bits_r == '0) ? 4'd1 : out_bits_r;
  assign frac  = 5'd16 - 5'(n_eff);

  assign dctl.step = advance;
  assign dctl.mode = dither_mode_r;
  assign dctl.bits = n_eff;

  sodd_dither u_dither (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dctl),
    .dith  (dith)
  );

  assign w_base = {~sample_r[31], sample_r[30:16]};
  assign w      = w_base + {err_last_r[14:0], 1'b0} - err_prev_r + dith;

  assign mask      = 16'hFFFF << frac;
  assign inc       = w[4'(15 - n_eff)] ? (16'd1 << frac) : '0;
  assign q         = (w & mask) + inc;
  assign e         = w - q;
  assign level_nxt = 15'(q >> frac);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_last_r  <= '0;
      err_prev_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        err_last_r  <= e;
        err_prev_r  <= err_last_r;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level_r <= level_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.level = level_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("computed word not presented");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(sample_r)))
    else $error("stalled input word lost");

  a_err_shift: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (err_prev_r == $past(err_last_r)))
    else $error("error history out of order");

  a_quant_grid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((q & ~mask) == '0))
    else $error("rounded word off the quantizer grid");

endmodule

`default_nettype wire

// ----- tb/sv/tb_second_order_sigma_delta_dither_unit.sv -----
`timescale 1ns / 100ps

module tb_second_order_sigma_delta_dither_unit;
  import sodd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned TAIL_ITEMS  = 120;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 130;

  localparam logic [15:0] MUL_A = 16'd25173;
  localparam logic [15:0] ADD_A = 16'd13847;
  localparam logic [14:0] MUL_B = 15'd24645;
  localparam logic [14:0] ADD_B = 15'd1703;
  localparam logic [31:0] MUL_W = 32'd214013;
  localparam logic [31:0] ADD_W = 32'd2531011;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [31:0] S_MIN  = 32'h8000_0000;
  localparam logic [31:0] S_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] S_ZERO = 32'h0000_0000;
  localparam logic [31:0] S_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_WRITE,
    CMD_DRAIN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [31:0]           sample;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cmd_t;

  logic clk;
  logic rst_n;

  sodd_in_if  in_ch ();
  sodd_out_if out_ch ();
  sodd_cfg_if cfg_ch ();

  second_order_sigma_delta_dither_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // modulator state as the testbench sees it
  logic [BITS_W-1:0] m_bits;
  dither_mode_t      m_mode;
  logic [15:0]       err1;
  logic [15:0]       err2;
  logic [15:0]       lcg16;
  logic [14:0]       lcg15;
  logic [31:0]       lcg32c;
  logic [31:0]       lcg32d;

  cmd_t               plan[$];
  logic [LEVEL_W-1:0] levels_due[$];
  logic [31:0]        ramp;

  int unsigned cycles;
  int unsigned n_fail;
  int unsigned n_samples;
  int unsigned n_writes;
  int unsigned n_levels;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned quiet;
  bit          in_calm;
  bit          out_calm;
  bit          in_took;
  bit          cfg_took;
  bit          tail;

  function automatic void reset_modulator();
    m_bits = 4'd6;
    m_mode = DM_WIDE;
    err1   = '0;
    err2   = '0;
    lcg16  = 16'hBEEF;
    lcg15  = 15'h700D;
    lcg32c = 32'hDEADBEEF;
    lcg32d = 32'hD00DFEED;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(idx))
      CFG_OUT_BITS:    m_bits = data;
      CFG_DITHER_MODE: m_mode = dither_mode_t'(data[1:0]);
      default: ;
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] quantize_sample(input logic [31:0] s);
    int unsigned n;
    int unsigned sh;
    logic [15:0] w;
    logic [15:0] mask;
    logic [15:0] rbit;
    logic [15:0] q;
    logic [31:0] wide_c;
    logic [31:0] wide_d;
    n = (m_bits == 0) ? 1 : m_bits;
    w = s[31:16] ^ 16'h8000;
    w = w + {err1[14:0], 1'b0} - err2;
    if (m_mode == DM_SINGLE || m_mode == DM_TPDF) begin
      lcg16 = 16'(lcg16 * MUL_A + ADD_A);
      w = w + 16'($signed(lcg16) >>> n);
    end
    if (m_mode == DM_TPDF) begin
      lcg15 = 15'(lcg15 * MUL_B + ADD_B);
      w = w + 16'(lcg15 >> (n - 1));
    end
    if (m_mode == DM_WIDE) begin
      lcg32c = lcg32c * MUL_W + ADD_W;
      lcg32d = lcg32d * MUL_W + ADD_W;
      sh = (n + 18 > 31) ? 31 : n + 18;
      wide_c = 32'($signed(lcg32c) >>> sh);
      wide_d = 32'($signed(lcg32d) >>> sh);
      w = w + wide_c[15:0];
      w = w + wide_d[15:0];
    end
    mask = 16'hFFFF << (16 - n);
    rbit = 16'h0001 << (15 - n);
    q = (w & mask) + ((w & rbit) << 1);
    err2 = err1;
    err1 = w - q;
    return LEVEL_W'(q >> (16 - n));
  endfunction

  task automatic add_sample(input logic [31:0] s);
    plan.push_back('{kind: CMD_SAMPLE, sample: s, idx: '0, data: '0});
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    plan.push_back('{kind: CMD_WRITE, sample: '0, idx: idx, data: data});
  endtask

  task automatic add_drain();
    plan.push_back('{kind: CMD_DRAIN, sample: '0, idx: '0, data: '0});
  endtask

  function automatic logic [31:0] audio_sample();
    case ($urandom_range(0, 9))
      0: return S_MIN;
      1: return S_MAX;
      2: return $urandom_range(0, 1) ? S_ZERO : S_ONES;
      3, 4, 5: begin
        ramp = ramp + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        return ramp;
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic build_plan();
    logic [BITS_W-1:0] bits;
    logic [1:0]        mode;
    logic [BITS_W-1:0] bit_pick [4];
    bit_pick = '{4'd15, 4'd1, 4'd0, 4'd8};
    ramp = $urandom();
    // reset settings
    add_sample(S_MIN);
    add_sample(S_MAX);
    add_sample(S_ZERO);
    add_sample(S_ONES);
    add_sample(32'h0000_8000);
    add_write(CFG_OUT_BITS, 4'd15);
    add_write(CFG_DITHER_MODE, {2'b00, DM_NONE});
    add_sample(S_MAX);
    add_sample(S_MIN);
    add_sample(32'h7FFF_0000);
    // zero resolution acts as one bit
    add_write(CFG_OUT_BITS, 4'd0);
    add_write(CFG_DITHER_MODE, {2'b00, DM_SINGLE});
    add_sample(S_MIN);
    add_sample(S_MAX);
    add_sample(S_ZERO);
    add_write(CFG_OUT_BITS, 4'd1);
    add_write(CFG_DITHER_MODE, {2'b01, DM_TPDF});
    add_sample(S_MAX);
    add_sample(S_MIN);
    add_sample(S_ONES);
    // dither shift past the word width
    add_write(CFG_OUT_BITS, 4'd15);
    add_write(CFG_DITHER_MODE, {2'b11, DM_WIDE});
    add_sample(32'h1234_5678);
    add_sample(S_MIN);
    add_sample(S_MAX);
    // round up past full scale
    add_write(CFG_OUT_BITS, 4'd4);
    add_write(CFG_DITHER_MODE, {2'b10, DM_NONE});
    add_write(CFG_SPARE_LO, 4'hF);
    add_sample(S_MAX);
    add_sample(S_MAX);
    add_sample(S_MAX);

    for (int p = 0; p < PHASES; p++) begin
      bits = (p < 4) ? bit_pick[p] : 4'($urandom_range(0, 15));
      mode = (p < 8) ? 2'(p % 4) : 2'($urandom_range(0, 3));
      if (p % 2) begin
        add_write(CFG_OUT_BITS, bits);
        add_write(CFG_DITHER_MODE, {2'($urandom_range(0, 3)), mode});
      end else begin
        add_write(CFG_DITHER_MODE, {2'($urandom_range(0, 3)), mode});
        add_write(CFG_OUT_BITS, bits);
      end
      if (p == 5) begin
        add_write(CFG_SPARE_LO, 4'($urandom_range(0, 15)));
        add_write(CFG_SPARE_HI, 4'($urandom_range(0, 15)));
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ((p == 3 || p == 9) && k == PHASE_ITEMS / 2)
          add_drain();
        add_sample(audio_sample());
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // source side: samples and register writes
  always @(negedge clk) begin : feed
    logic nv_in;
    logic nv_cfg;
    cmd_t c;
    nv_in  = 1'b0;
    nv_cfg = 1'b0;
    if (rst_n && ((in_ch.valid && !in_took) || (cfg_ch.valid && !cfg_took))) begin
      nv_in  = in_ch.valid;
      nv_cfg = cfg_ch.valid;
    end else if (rst_n && plan.size() > 0) begin
      c = plan[0];
      if (c.kind == CMD_SAMPLE) begin
        quiet = 0;
        if ($urandom_range(0, 63) == 0)
          in_calm = !in_calm;
        if (in_gap > 0) begin
          in_gap--;
        end else if (!in_calm && !tail && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 13);
        end else begin
          nv_in = 1'b1;
          in_ch.sample <= c.sample;
          void'(plan.pop_front());
        end
      end else if (levels_due.size() != 0) begin
        quiet = 0;
      end else if (quiet < SETTLE_CYC) begin
        quiet++;
      end else begin
        quiet = 0;
        if (c.kind == CMD_WRITE) begin
          nv_cfg = 1'b1;
          cfg_ch.index <= c.idx;
          cfg_ch.data  <= c.data;
        end
        void'(plan.pop_front());
      end
    end
    in_ch.valid  <= nv_in;
    cfg_ch.valid <= nv_cfg;
  end

  // sink side: output backpressure
  always @(negedge clk) begin : take
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 79) == 0)
        out_calm = !out_calm;
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else if (!out_calm && !tail && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch
    logic [LEVEL_W-1:0] want;
    cycles++;
    if (!rst_n) begin
      in_took  <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      in_took  <= in_ch.valid && in_ch.ready;
      cfg_took <= cfg_ch.valid && cfg_ch.ready;
      tail     <= plan.size() <= TAIL_ITEMS;
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_write(cfg_ch.index, cfg_ch.data);
        n_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        levels_due.push_back(quantize_sample(in_ch.sample));
        n_samples++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_levels++;
        if (levels_due.size() == 0) begin
          $error("level: expected none, actual %0d", out_ch.level);
          n_fail++;
        end else begin
          want = levels_due.pop_front();
          if (out_ch.level !== want) begin
            $error("level: expected %0d, actual %0d", want, out_ch.level);
            n_fail++;
          end
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    reset_modulator();
    build_plan();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (plan.size() != 0 || in_ch.valid || cfg_ch.valid || levels_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Stimulus: %0d samples, %0d register writes, resolutions 0..15, all dither modes",
             n_samples, n_writes);
    $display("Checked %0d levels in %0d cycles, %0d mismatches", n_levels, cycles, n_fail);
    if (n_fail == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
